@@ sv/hi_hihi_safety_trip_monitor_core_defines.svh @@
// Assertion macros for the HI/HIHI trip monitor.
`ifndef HI_HIHI_SAFETY_TRIP_MONITOR_CORE_DEFINES_SVH
`define HI_HIHI_SAFETY_TRIP_MONITOR_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define HHSTM_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hhstm check failed: same-cycle rule");

// Next-cycle implication, checked out of reset.
`define HHSTM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hhstm check failed: next-cycle rule");

`endif

@@ sv/hhstm_pkg.sv @@
package hhstm_pkg;

    localparam int unsigned NUM_LIMITS = 6;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned SAMPLE_W   = 16;

    // Threshold register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CUR_HI    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CUR_HIHI  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ESC_HI    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ESC_HIHI  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MOT_HI    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MOT_HIHI  = 3'd5;

    localparam logic signed [SAMPLE_W-1:0] LIMIT_RESET = -16'sd1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef enum logic [1:0] {
        LVL_UNKNOWN = 2'd0,
        LVL_NORMAL  = 2'd1,
        LVL_HI      = 2'd2,
        LVL_HIHI    = 2'd3
    } level_t;

    typedef enum logic [1:0] {
        CAUSE_NONE    = 2'd0,
        CAUSE_CURRENT = 2'd1,
        CAUSE_ESC     = 2'd2,
        CAUSE_MOTOR   = 2'd3
    } cause_t;

    // Trip and stop-request status of one tick
    typedef struct packed {
        logic   trip_latched;
        cause_t trip_cause;
        logic   motor_stop_pulse;
        logic   test_abort_pulse;
        logic   stop_taken;
        cause_t stop_taken_cause;
    } trip_status_t;

endpackage

@@ sv/hhstm_grade.sv @@
module hhstm_grade
    import hhstm_pkg::*;
(
    input  logic    avail,
    input  sample_t value,
    input  sample_t hi_limit,
    input  sample_t hihi_limit,
    output level_t  level
);

    // A negative limit disables its check.
    always_comb begin
        if (!avail) begin
            level = LVL_UNKNOWN;
        end else if (!hihi_limit[SAMPLE_W-1] && (value >= hihi_limit)) begin
            level = LVL_HIHI;
        end else if (!hi_limit[SAMPLE_W-1] && (value >= hi_limit)) begin
            level = LVL_HI;
        end else begin
            level = LVL_NORMAL;
        end
    end

endmodule

@@ sv/hhstm_trip.sv @@
module hhstm_trip
    import hhstm_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         advance,
    input  level_t       current_level,
    input  level_t       esc_temp_level,
    input  level_t       motor_temp_level,
    input  logic         throttle_idle,
    input  logic         test_running,
    input  logic         stop_ack,
    output trip_status_t status
);

    logic   trip_active_reg,  trip_active_next;
    cause_t trip_reason_reg,  trip_reason_next;
    logic   stop_pending_reg, stop_pending_next;
    cause_t stop_reason_reg,  stop_reason_next;

    cause_t cause;
    logic   pulse;
    logic   pend_mid;
    cause_t reason_mid;

    always_comb begin
        // first HIHI channel wins
        if (current_level == LVL_HIHI) begin
            cause = CAUSE_CURRENT;
        end else if (esc_temp_level == LVL_HIHI) begin
            cause = CAUSE_ESC;
        end else if (motor_temp_level == LVL_HIHI) begin
            cause = CAUSE_MOTOR;
        end else begin
            cause = CAUSE_NONE;
        end

        trip_active_next = trip_active_reg;
        trip_reason_next = trip_reason_reg;
        pend_mid         = stop_pending_reg;
        reason_mid       = stop_reason_reg;
        pulse            = 1'b0;

        if (cause != CAUSE_NONE) begin
            if (!(trip_active_reg && (trip_reason_reg == cause))) begin
                trip_active_next = 1'b1;
                trip_reason_next = cause;
                pend_mid         = 1'b1;
                reason_mid       = cause;
                pulse            = 1'b1;
            end
        end else if (trip_active_reg && throttle_idle && !test_running) begin
            trip_active_next = 1'b0;
            trip_reason_next = CAUSE_NONE;
            pend_mid         = 1'b0;
            reason_mid       = CAUSE_NONE;
        end

        // serve the acknowledge after the trip update
        stop_pending_next = pend_mid;
        stop_reason_next  = reason_mid;
        status.stop_taken       = 1'b0;
        status.stop_taken_cause = CAUSE_NONE;
        if (stop_ack && pend_mid) begin
            status.stop_taken       = 1'b1;
            status.stop_taken_cause = reason_mid;
            stop_pending_next       = 1'b0;
            stop_reason_next        = CAUSE_NONE;
        end

        status.trip_latched     = trip_active_next;
        status.trip_cause       = trip_active_next ? trip_reason_next : CAUSE_NONE;
        status.motor_stop_pulse = pulse;
        status.test_abort_pulse = pulse && test_running;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trip_active_reg  <= 1'b0;
            trip_reason_reg  <= CAUSE_NONE;
            stop_pending_reg <= 1'b0;
            stop_reason_reg  <= CAUSE_NONE;
        end else if (advance) begin
            trip_active_reg  <= trip_active_next;
            trip_reason_reg  <= trip_reason_next;
            stop_pending_reg <= stop_pending_next;
            stop_reason_reg  <= stop_reason_next;
        end
    end

endmodule

@@ sv/hi_hihi_safety_trip_monitor_core.sv @@
// HI/HIHI safety trip monitor.
// An accepted input beat passes through the input register, then grading
// and trip update into the result register. One tick per cycle while the
// output does not stall; the trip latch updates once per tick.
// Reset (aresetn low, synchronous): all limits read -1 (disabled), trip and
// stop request clear, both pipeline stages empty.
`include "hi_hihi_safety_trip_monitor_core_defines.svh"

module hi_hihi_safety_trip_monitor_core
    import hhstm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    // Threshold write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,

    // Tick input
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [15:0] current_sample, [31:16] esc_temp_sample, [47:32] motor_temp_sample,
    // [48] throttle_idle, [49] test_running, [50] stop_ack, [55:51] zero
    input  logic [55:0]          s_tdata,
    // [0] telemetry_valid, [1] motor_temp_valid
    input  logic [1:0]           s_tuser,

    // Result output
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [1:0] current_level, [3:2] esc_temp_level, [5:4] motor_temp_level,
    // [6] trip_latched, [8:7] trip_cause, [9] motor_stop_pulse,
    // [10] test_abort_pulse, [11] stop_taken, [13:12] stop_taken_cause, [15:14] zero
    output logic [15:0]          m_tdata
);

    // ---------------------------------------------------------------
    // Threshold registers. The user writes them only while the block is
    // idle, not enforced by the block, so the grading stage reads them directly.
    // ---------------------------------------------------------------
    sample_t limit_reg [NUM_LIMITS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_LIMITS; i++) begin
                limit_reg[i] <= LIMIT_RESET;
            end
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_CUR_HI:   limit_reg[REG_CUR_HI]   <= cfg_data;
                REG_CUR_HIHI: limit_reg[REG_CUR_HIHI] <= cfg_data;
                REG_ESC_HI:   limit_reg[REG_ESC_HI]   <= cfg_data;
                REG_ESC_HIHI: limit_reg[REG_ESC_HIHI] <= cfg_data;
                REG_MOT_HI:   limit_reg[REG_MOT_HI]   <= cfg_data;
                REG_MOT_HIHI: limit_reg[REG_MOT_HIHI] <= cfg_data;
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline control. The result register frees up whenever it is
    // empty or its beat is taken; the input register then moves on.
    // ---------------------------------------------------------------
    logic in_valid_reg;
    logic out_valid_reg;
    logic advance;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;

    // Input register: capture the accepted beat
    logic    tlm_valid_reg;
    logic    mot_valid_reg;
    sample_t cur_reg;
    sample_t esc_reg;
    sample_t mot_reg;
    logic    idle_reg;
    logic    test_reg;
    logic    ack_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            tlm_valid_reg <= s_tuser[0];
            mot_valid_reg <= s_tuser[1];
            cur_reg       <= s_tdata[15:0];
            esc_reg       <= s_tdata[31:16];
            mot_reg       <= s_tdata[47:32];
            idle_reg      <= s_tdata[48];
            test_reg      <= s_tdata[49];
            ack_reg       <= s_tdata[50];
        end
    end

    // ---------------------------------------------------------------
    // Grade each channel against its two limits
    // ---------------------------------------------------------------
    level_t lvl_cur, lvl_esc, lvl_mot;

    hhstm_grade u_grade_cur (
        .avail      (tlm_valid_reg),
        .value      (cur_reg),
        .hi_limit   (limit_reg[REG_CUR_HI]),
        .hihi_limit (limit_reg[REG_CUR_HIHI]),
        .level      (lvl_cur)
    );

    hhstm_grade u_grade_esc (
        .avail      (tlm_valid_reg),
        .value      (esc_reg),
        .hi_limit   (limit_reg[REG_ESC_HI]),
        .hihi_limit (limit_reg[REG_ESC_HIHI]),
        .level      (lvl_esc)
    );

    hhstm_grade u_grade_mot (
        .avail      (mot_valid_reg),
        .value      (mot_reg),
        .hi_limit   (limit_reg[REG_MOT_HI]),
        .hihi_limit (limit_reg[REG_MOT_HIHI]),
        .level      (lvl_mot)
    );

    // ---------------------------------------------------------------
    // Trip latch and stop request. State advances once per tick, at
    // the edge the tick moves into the result register.
    // ---------------------------------------------------------------
    trip_status_t trip_status;
    logic         tick_step;

    assign tick_step = in_valid_reg && advance;

    hhstm_trip u_trip (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .advance          (tick_step),
        .current_level    (lvl_cur),
        .esc_temp_level   (lvl_esc),
        .motor_temp_level (lvl_mot),
        .throttle_idle    (idle_reg),
        .test_running     (test_reg),
        .stop_ack         (ack_reg),
        .status           (trip_status)
    );

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    level_t       lvl_cur_reg, lvl_esc_reg, lvl_mot_reg;
    trip_status_t status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_step) begin
            lvl_cur_reg <= lvl_cur;
            lvl_esc_reg <= lvl_esc;
            lvl_mot_reg <= lvl_mot;
            status_reg  <= trip_status;
        end
    end

    assign m_tdata = {2'b00,
                      status_reg.stop_taken_cause,
                      status_reg.stop_taken,
                      status_reg.test_abort_pulse,
                      status_reg.motor_stop_pulse,
                      status_reg.trip_cause,
                      status_reg.trip_latched,
                      lvl_mot_reg,
                      lvl_esc_reg,
                      lvl_cur_reg};

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    // A stop pulse always leaves a latched trip with a named cause.
    `HHSTM_ASSERT_NOW(a_pulse_latches, aclk, aresetn,
        out_valid_reg && status_reg.motor_stop_pulse,
        status_reg.trip_latched && (status_reg.trip_cause != CAUSE_NONE))
    // Test abort only rides on a stop pulse.
    `HHSTM_ASSERT_NOW(a_abort_on_pulse, aclk, aresetn,
        out_valid_reg && status_reg.test_abort_pulse, status_reg.motor_stop_pulse)
    // A taken stop request always reports its cause.
    `HHSTM_ASSERT_NOW(a_taken_cause, aclk, aresetn,
        out_valid_reg && status_reg.stop_taken, status_reg.stop_taken_cause != CAUSE_NONE)
    // A tick held in the input register while the output stalls is not lost.
    `HHSTM_ASSERT_NEXT(a_hold_tick, aclk, aresetn, in_valid_reg && !advance,
        in_valid_reg && $stable(cur_reg) && $stable(ack_reg))

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import hhstm_pkg::*;

    localparam int unsigned RESET_CYCLES    = 7;
    localparam int unsigned LATENCY         = 2;
    localparam int unsigned HOLD_OFF_CYCLES = 60;
    localparam int unsigned WATCHDOG_LIMIT  = 1500;
    localparam int unsigned MAX_REPORTED    = 10;
    localparam int unsigned RANDOM_PHASES   = 8;
    localparam int unsigned TICKS_PER_PHASE = 54;

    // One monitoring tick as it enters the block
    typedef struct {
        logic    tlm_ok;
        sample_t cur;
        sample_t esc;
        logic    mot_ok;
        sample_t mot;
        logic    idle;
        logic    testing;
        logic    ack;
    } tick_t;

    // Grades and trip status reported for one tick
    typedef struct {
        level_t       cur_lvl;
        level_t       esc_lvl;
        level_t       mot_lvl;
        trip_status_t status;
    } tick_verdict_t;

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_style_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [55:0]          s_tdata   = '0;
    logic [1:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [15:0]          m_tdata;

    // Threshold copy and trip latch state tracked alongside the block
    sample_t limit_reg [NUM_LIMITS] = '{default: LIMIT_RESET};
    logic    trip_on  = 1'b0;
    cause_t  trip_why = CAUSE_NONE;
    logic    stop_req = 1'b0;
    cause_t  stop_why = CAUSE_NONE;

    tick_verdict_t verdict_q [$];
    int unsigned   mismatch_count = 0;
    int unsigned   results_seen   = 0;

    // Sender and receiver idling controls
    bit          sender_gappy = 1'b1;
    int unsigned burst_left   = 0;
    rx_style_t   rx_mode      = RX_RANDOM;
    bit          hold_off_req = 1'b0;

    hi_hihi_safety_trip_monitor_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin : clock_gen
        forever #2 aclk = ~aclk;
    end

    // Grade one channel: unknown when absent, then HIHI, then HI, else normal.
    // A negative threshold switches its check off.
    function automatic level_t grade_channel(input logic present, input sample_t value,
                                             input sample_t hi, input sample_t hihi);
        if (!present)
            return LVL_UNKNOWN;
        if (hihi >= 0 && value >= hihi)
            return LVL_HIHI;
        if (hi >= 0 && value >= hi)
            return LVL_HI;
        return LVL_NORMAL;
    endfunction

    // Grade a tick, update the trip latch and the stop request, then serve
    // the acknowledge. Returns what the block should report for this tick.
    function automatic tick_verdict_t grade_and_latch(input tick_t t);
        tick_verdict_t v;
        cause_t        hit;

        v.cur_lvl = grade_channel(t.tlm_ok, t.cur, limit_reg[REG_CUR_HI],
                                  limit_reg[REG_CUR_HIHI]);
        v.esc_lvl = grade_channel(t.tlm_ok, t.esc, limit_reg[REG_ESC_HI],
                                  limit_reg[REG_ESC_HIHI]);
        v.mot_lvl = grade_channel(t.mot_ok, t.mot, limit_reg[REG_MOT_HI],
                                  limit_reg[REG_MOT_HIHI]);

        // First channel at HIHI wins: current, then ESC, then motor
        if (v.cur_lvl == LVL_HIHI)
            hit = CAUSE_CURRENT;
        else if (v.esc_lvl == LVL_HIHI)
            hit = CAUSE_ESC;
        else if (v.mot_lvl == LVL_HIHI)
            hit = CAUSE_MOTOR;
        else
            hit = CAUSE_NONE;

        v.status.motor_stop_pulse = 1'b0;
        if (hit != CAUSE_NONE) begin
            // Fire only on a new trip or a changed cause
            if (!(trip_on && trip_why == hit)) begin
                trip_on  = 1'b1;
                trip_why = hit;
                stop_req = 1'b1;
                stop_why = hit;
                v.status.motor_stop_pulse = 1'b1;
            end
        end else if (trip_on && t.idle && !t.testing) begin
            trip_on  = 1'b0;
            trip_why = CAUSE_NONE;
            stop_req = 1'b0;
            stop_why = CAUSE_NONE;
        end

        // Acknowledge comes after the latch update within the tick
        v.status.stop_taken       = 1'b0;
        v.status.stop_taken_cause = CAUSE_NONE;
        if (t.ack && stop_req) begin
            v.status.stop_taken       = 1'b1;
            v.status.stop_taken_cause = stop_why;
            stop_req = 1'b0;
            stop_why = CAUSE_NONE;
        end

        v.status.trip_latched     = trip_on;
        v.status.trip_cause       = trip_on ? trip_why : CAUSE_NONE;
        v.status.test_abort_pulse = v.status.motor_stop_pulse && t.testing;
        return v;
    endfunction

    function automatic tick_t mk_tick(input logic tlm_ok, input sample_t cur, input sample_t esc,
                                      input logic mot_ok, input sample_t mot, input logic idle,
                                      input logic testing, input logic ack);
        tick_t t;
        t.tlm_ok  = tlm_ok;
        t.cur     = cur;
        t.esc     = esc;
        t.mot_ok  = mot_ok;
        t.mot     = mot;
        t.idle    = idle;
        t.testing = testing;
        t.ack     = ack;
        return t;
    endfunction

    // Half the time land close to a threshold so both sides of each compare get hit
    function automatic sample_t pick_sample(input sample_t hi, input sample_t hihi);
        int v;
        case ($urandom_range(5, 0))
            0:       return sample_t'($urandom);
            1, 2:    v = int'(hihi) + int'($urandom_range(6, 0)) - 3;
            3:       v = int'(hi) + int'($urandom_range(6, 0)) - 3;
            4:       v = $urandom_range(1, 0) ? 32767 : -32768;
            default: v = int'($urandom_range(20000, 0)) - 2000;
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return sample_t'(v);
    endfunction

    function automatic sample_t pick_limit();
        case ($urandom_range(9, 0))
            0:       return LIMIT_RESET;
            1:       return sample_t'(0);
            2:       return sample_t'(32767);
            default: return sample_t'($urandom_range(15000, 0));
        endcase
    endfunction

    function automatic tick_t random_tick();
        tick_t t;
        t.tlm_ok  = $urandom_range(7, 0) != 0;
        t.cur     = pick_sample(limit_reg[REG_CUR_HI], limit_reg[REG_CUR_HIHI]);
        t.esc     = pick_sample(limit_reg[REG_ESC_HI], limit_reg[REG_ESC_HIHI]);
        t.mot_ok  = $urandom_range(7, 0) != 0;
        t.mot     = pick_sample(limit_reg[REG_MOT_HI], limit_reg[REG_MOT_HIHI]);
        t.idle    = $urandom_range(1, 0) != 0;
        t.testing = $urandom_range(3, 0) == 0;
        t.ack     = $urandom_range(2, 0) == 0;
        return t;
    endfunction

    // Offer one tick and hold it until the block takes the beat
    task automatic send_tick(input tick_t t);
        int unsigned gap;
        if (sender_gappy && burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            gap        = $urandom_range(6, 0);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, t.ack, t.testing, t.idle, t.mot, t.esc, t.cur};
        s_tuser  <= {t.mot_ok, t.tlm_ok};
        do @(posedge aclk); while (!s_tready);
        verdict_q.push_back(grade_and_latch(t));
        if (burst_left != 0)
            burst_left--;
    endtask

    // Drop the input and wait until every pending verdict has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (verdict_q.size() != 0);
    endtask

    // Write all six thresholds, plus the unused indexes, once the block is idle
    task automatic set_limits(input sample_t cur_hi, input sample_t cur_hihi,
                              input sample_t esc_hi, input sample_t esc_hihi,
                              input sample_t mot_hi, input sample_t mot_hihi);
        sample_t want [NUM_LIMITS];
        want[REG_CUR_HI]   = cur_hi;
        want[REG_CUR_HIHI] = cur_hihi;
        want[REG_ESC_HI]   = esc_hi;
        want[REG_ESC_HIHI] = esc_hihi;
        want[REG_MOT_HI]   = mot_hi;
        want[REG_MOT_HIHI] = mot_hihi;
        drain_results();
        for (int r = 0; r < (1 << CFG_IDX_W); r++) begin
            cfg_valid <= 1'b1;
            cfg_index <= r[CFG_IDX_W-1:0];
            if (r < NUM_LIMITS)
                cfg_data <= want[r];
            else
                cfg_data <= 16'($urandom);
            do @(posedge aclk); while (!cfg_ready);
            if (r < NUM_LIMITS)
                limit_reg[r] = want[r];
        end
        cfg_valid <= 1'b0;
    endtask

    // Reset thresholds are all disabled: every valid channel reads normal
    task automatic test_reset_limits();
        send_tick(mk_tick(1, 32767, -32768, 1, 32767, 0, 0, 1));
        send_tick(mk_tick(0, -32768, 32767, 0, -32768, 1, 1, 0));
        send_tick(mk_tick(1, 0, -1, 1, 0, 1, 0, 1));
    endtask

    // Values just under and at each HI threshold, then full scale on invalid channels
    task automatic test_threshold_grading();
        set_limits(1000, 2000, 5000, 8000, 6000, 9000);
        send_tick(mk_tick(1, 999, 4999, 1, 5999, 0, 0, 0));
        send_tick(mk_tick(1, 1000, 5000, 1, 6000, 0, 0, 0));
        send_tick(mk_tick(0, 32767, 32767, 0, 32767, 1, 0, 0));
    endtask

    // Latch behavior: new trip, same cause, cause change, hold and clear,
    // acknowledge in the same tick, acknowledge with nothing pending
    task automatic test_trip_latch();
        send_tick(mk_tick(1, 0, 0, 1, 9000, 0, 1, 0));
        send_tick(mk_tick(1, 0, 0, 1, 9500, 0, 1, 0));
        send_tick(mk_tick(1, 0, 8000, 1, 9000, 0, 0, 0));
        send_tick(mk_tick(1, 2000, 8000, 1, 9000, 0, 0, 1));
        send_tick(mk_tick(1, 0, 0, 1, 0, 0, 0, 0));
        send_tick(mk_tick(1, 0, 0, 1, 0, 1, 1, 0));
        send_tick(mk_tick(1, 0, 0, 1, 0, 1, 0, 1));
        send_tick(mk_tick(1, 2500, 0, 1, 0, 1, 0, 0));
        send_tick(mk_tick(1, 0, 0, 1, 0, 1, 0, 1));
        send_tick(mk_tick(1, 2000, 0, 1, 0, 0, 0, 0));
        send_tick(mk_tick(1, 2000, 0, 1, 0, 0, 0, 1));
        send_tick(mk_tick(1, 2000, 0, 1, 0, 0, 0, 1));
    endtask

    // HI above HIHI, then all thresholds at zero, then all at full scale
    task automatic test_extreme_limits();
        set_limits(3000, 2000, 0, 32767, 32767, 0);
        send_tick(mk_tick(1, 2500, 0, 1, -1, 0, 0, 0));
        send_tick(mk_tick(1, 1999, 32767, 1, 0, 1, 0, 1));
        send_tick(mk_tick(1, -32768, -1, 1, -32768, 1, 0, 1));
        set_limits(0, 0, 0, 0, 0, 0);
        send_tick(mk_tick(1, 0, 0, 1, 0, 1, 1, 0));
        send_tick(mk_tick(1, -1, -1, 1, -1, 1, 0, 1));
        set_limits(32767, 32767, 32767, 32767, 32767, 32767);
        send_tick(mk_tick(1, 32767, 32767, 1, 32767, 0, 0, 1));
        send_tick(mk_tick(1, 32766, 32766, 1, 32766, 1, 0, 0));
    endtask

    // Stall the result side for a long stretch while ticks keep coming
    task automatic test_backpressure();
        set_limits(500, 1500, 4000, 7000, 5000, 8000);
        rx_mode      = RX_ALWAYS;
        sender_gappy = 1'b0;
        hold_off_req = 1'b1;
        repeat (24) send_tick(random_tick());
        sender_gappy = 1'b1;
    endtask

    // Random thresholds per phase, ticks near them, idling style rotated
    task automatic test_random_ticks();
        sample_t lim [NUM_LIMITS];
        sample_t swap;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            for (int r = 0; r < NUM_LIMITS; r++)
                lim[r] = pick_limit();
            // Keep HI below HIHI on most phases
            if ($urandom_range(3, 0) != 0) begin
                for (int r = 0; r < NUM_LIMITS; r += 2) begin
                    if (lim[r] > lim[r+1]) begin
                        swap     = lim[r];
                        lim[r]   = lim[r+1];
                        lim[r+1] = swap;
                    end
                end
            end
            set_limits(lim[REG_CUR_HI], lim[REG_CUR_HIHI], lim[REG_ESC_HI],
                       lim[REG_ESC_HIHI], lim[REG_MOT_HI], lim[REG_MOT_HIHI]);
            rx_mode      = rx_style_t'(p % 3);
            sender_gappy = (p % 4) != 0;
            repeat (TICKS_PER_PHASE) send_tick(random_tick());
        end
    endtask

    // Receiver: honor a long hold-off when asked, otherwise follow the style
    initial begin : receiver
        int unsigned beat_phase;
        beat_phase = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            beat_phase++;
            case (rx_mode)
                RX_ALWAYS:  m_tready <= 1'b1;
                RX_RANDOM:  m_tready <= $urandom_range(99, 0) < 60;
                default:    m_tready <= (beat_phase % 9) < 5;
            endcase
        end
    end

    task automatic check_field(input string what, input logic [1:0] want_v,
                               input logic [1:0] got_v);
        if (got_v !== want_v) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTED)
                $display("result %0d: %s expected %0d, got %0d",
                         results_seen, what, want_v, got_v);
        end
    endtask

    // Compare every result beat with the oldest pending verdict
    always @(posedge aclk) begin : check_results
        tick_verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTED)
                    $display("result %0d: beat with no tick pending, data %h",
                             results_seen, m_tdata);
            end else begin
                want = verdict_q.pop_front();
                check_field("current_level", want.cur_lvl, m_tdata[1:0]);
                check_field("esc_temp_level", want.esc_lvl, m_tdata[3:2]);
                check_field("motor_temp_level", want.mot_lvl, m_tdata[5:4]);
                check_field("trip_latched", {1'b0, want.status.trip_latched},
                            {1'b0, m_tdata[6]});
                check_field("trip_cause", want.status.trip_cause, m_tdata[8:7]);
                check_field("motor_stop_pulse", {1'b0, want.status.motor_stop_pulse},
                            {1'b0, m_tdata[9]});
                check_field("test_abort_pulse", {1'b0, want.status.test_abort_pulse},
                            {1'b0, m_tdata[10]});
                check_field("stop_taken", {1'b0, want.status.stop_taken},
                            {1'b0, m_tdata[11]});
                check_field("stop_taken_cause", want.status.stop_taken_cause,
                            m_tdata[13:12]);
            end
            results_seen++;
        end
    end

    // End the run when no beat moves on any channel for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : run
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_limits();
        test_threshold_grading();
        test_trip_latch();
        test_extreme_limits();
        test_backpressure();
        test_random_ticks();
        drain_results();
        // Let any stray beat show up before judging
        repeat (LATENCY + 4) @(posedge aclk);
        if (verdict_q.size() != 0) begin
            mismatch_count++;
            $display("%0d ticks never produced a result", verdict_q.size());
        end
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/hhstm_pkg.sv
sv/hhstm_grade.sv
sv/hhstm_trip.sv
sv/hi_hihi_safety_trip_monitor_core.sv
tb/sv/testbench.sv
